// ===== hdl/swot_pkg.sv =====
`timescale 1ns / 1ps

package swot_pkg;

	// Default sizing
	localparam int MAX_LEN_DEF     = 1024;
	localparam int SAMPLE_BITS_DEF = 10;

	// Threshold register
	localparam int              THR_W     = 20;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

	// Reported length width
	localparam int LEN_W = 11;

	// Request commands
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_END  = 1'b1;

endpackage

// ===== hdl/shortest_window_over_threshold_core.sv =====
`timescale 1ns / 1ps

// Shortest window over threshold. A push request appends one sample to a ring of MAX_LEN
// entries held in a synchronous RAM and adds it to the running sum; the block then trims
// the window from its oldest end while the sum is strictly above the threshold register,
// keeping the shortest qualifying length. An end request returns found, shortest_length
// and overflow through an output register and clears the sequence; the threshold keeps
// its value. Pushes beyond MAX_LEN samples in one sequence are dropped and set overflow.
// After a push the block checks the window; each sample trimmed takes a RAM read of the
// oldest sample and the subtract that follows it. Each sample is trimmed at most once,
// and no new request is taken until the check and trimming are done. A push is accepted
// while a result still waits on the output; an end request waits until the output
// register is free or being taken in the same cycle. No clearing pass after reset.
module shortest_window_over_threshold_core #(
	parameter int MAX_LEN     = swot_pkg::MAX_LEN_DEF,
	parameter int SAMPLE_BITS = swot_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// threshold register
	input  logic                          cfg_we,
	input  logic [swot_pkg::THR_W-1:0]    cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [SAMPLE_BITS-1:0]        sample_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [swot_pkg::LEN_W-1:0]    shortest_length,
	output logic                          overflow
);

	localparam int PTR_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int CMP_W = (SUM_W > swot_pkg::THR_W) ? SUM_W : swot_pkg::THR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_POP
	} state_t;

	state_t                     state_q;
	logic [swot_pkg::THR_W-1:0] threshold_q;
	logic [PTR_W-1:0]           head_q;
	logic [PTR_W-1:0]           tail_q;
	logic [CNT_W-1:0]           count_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           best_q;
	logic                       best_valid_q;
	logic [CNT_W-1:0]           seen_q;
	logic                       ovf_q;
	logic                       out_valid_q;
	logic                       found_q;
	logic [swot_pkg::LEN_W-1:0] length_q;
	logic                       overflow_q;

	logic                       accept;
	logic                       full;
	logic                       qualify;
	logic                       wr_en;
	logic                       rd_en;
	logic [SAMPLE_BITS-1:0]     rd_data;
	logic [PTR_W-1:0]           head_nxt;
	logic [PTR_W-1:0]           tail_nxt;

	// Handshake: pushes never wait on the output register
	assign in_ready = (state_q == ST_IDLE) &&
	                  (command == swot_pkg::CMD_PUSH || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign full     = seen_q >= CNT_W'(MAX_LEN);

	// Window test
	assign qualify  = (CMP_W'(sum_q) > CMP_W'(threshold_q)) && (count_q != '0);

	// Ring pointer wrap
	assign head_nxt = (head_q == PTR_W'(MAX_LEN - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_W'(MAX_LEN - 1)) ? '0 : tail_q + 1'b1;

	// RAM requests
	assign wr_en = accept && command == swot_pkg::CMD_PUSH && !full;
	assign rd_en = (state_q == ST_CHECK) && qualify;

	swot_ram #(
		.DEPTH (MAX_LEN),
		.WIDTH (SAMPLE_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (sample_value),
		.rd_en   (rd_en),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= swot_pkg::THR_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			best_q       <= '0;
			best_valid_q <= 1'b0;
			seen_q       <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			length_q     <= '0;
			overflow_q   <= 1'b0;
		end else begin
			// Output register: loaded by an end request, emptied when taken
			if (accept && command == swot_pkg::CMD_END) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == swot_pkg::CMD_END) begin
						found_q      <= best_valid_q;
						length_q     <= best_valid_q ? swot_pkg::LEN_W'(best_q) : '0;
						overflow_q   <= ovf_q;
						head_q       <= '0;
						tail_q       <= '0;
						count_q      <= '0;
						sum_q        <= '0;
						best_q       <= '0;
						best_valid_q <= 1'b0;
						seen_q       <= '0;
						ovf_q        <= 1'b0;
					end else if (accept && full) begin
						ovf_q <= 1'b1;
					end else if (accept) begin
						tail_q  <= tail_nxt;
						count_q <= count_q + 1'b1;
						seen_q  <= seen_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(sample_value);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (qualify) begin
						if (!best_valid_q || count_q < best_q) begin
							best_q       <= count_q;
							best_valid_q <= 1'b1;
						end
						state_q <= ST_POP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					// oldest sample now on the read port
					sum_q   <= sum_q - SUM_W'(rd_data);
					head_q  <= head_nxt;
					count_q <= count_q - 1'b1;
					state_q <= ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign shortest_length = length_q;
	assign overflow        = overflow_q;

endmodule

// ===== hdl/swot_ram.sv =====
`timescale 1ns / 1ps

// Single-port-write, single-port-read sample ring, registered read data
module swot_ram #(
	parameter int DEPTH = swot_pkg::MAX_LEN_DEF,
	parameter int WIDTH = swot_pkg::SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/swot_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the shortest window core
module swot_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       command,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       found,
	input logic [swot_pkg::LEN_W-1:0] shortest_length,
	input logic                       overflow
);

	logic push_acc;
	assign push_acc = in_valid && in_ready && command == swot_pkg::CMD_PUSH;

	// A pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(shortest_length) && $stable(overflow))
		else $error("result changed while stalled");

	// Not found always reports a zero length
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> shortest_length == '0)
		else $error("length set without a qualifying window");

	// A qualifying window has at least one sample
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> shortest_length != '0)
		else $error("zero length reported as found");

	// A push never produces a result
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		push_acc && !out_valid |=> !out_valid)
		else $error("result raised by a push");

endmodule

bind shortest_window_over_threshold_core swot_checker u_swot_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.command         (command),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.found           (found),
	.shortest_length (shortest_length),
	.overflow        (overflow)
);

// ===== test/shortest_window_over_threshold_core_tb.sv =====
`timescale 1ns / 1ps

module shortest_window_over_threshold_core_tb;

	localparam int MAX_LEN       = swot_pkg::MAX_LEN_DEF;
	localparam int SAMPLE_BITS   = swot_pkg::SAMPLE_BITS_DEF;
	localparam int THR_W         = swot_pkg::THR_W;
	localparam int LEN_W         = swot_pkg::LEN_W;
	localparam int PTR_W         = $clog2(MAX_LEN);
	localparam int SETTLE_CYCLES = 2 * MAX_LEN + 16;
	localparam int CYCLE_LIMIT   = 800000;
	localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] length;
		logic             overflow;
	} window_report_t;

	// DUT connections, inputs all driven from time zero
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [THR_W-1:0]       cfg_wdata    = '0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic                   command      = swot_pkg::CMD_PUSH;
	logic [SAMPLE_BITS-1:0] sample_value = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic                   found;
	logic [LEN_W-1:0]       shortest_length;
	logic                   overflow;

	// Traffic shaping
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int hold_left      = 0;

	// Bookkeeping
	int unsigned cycle_count = 0;
	int          error_count = 0;
	int          request_count = 0;
	int          report_count = 0;
	int          cfg_count = 0;

	// Predictor state: the sliding window and its running figures
	logic [SAMPLE_BITS-1:0] win_mem [MAX_LEN];
	logic [PTR_W-1:0]       win_head;
	logic [PTR_W-1:0]       win_tail;
	logic [LEN_W-1:0]       win_len;
	logic [20:0]            win_sum;
	logic [LEN_W-1:0]       best_len;
	logic                   best_ok;
	logic [LEN_W-1:0]       seq_samples;
	logic                   seq_overflow;
	logic [THR_W-1:0]       thr_reg;

	window_report_t pending_reports [$];

	shortest_window_over_threshold_core #(
		.MAX_LEN     (MAX_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.sample_value    (sample_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.shortest_length (shortest_length),
		.overflow        (overflow)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("shortest_window_over_threshold_core: mismatch");
			$finish;
		end
	end

	// Result side: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		error_count++;
	endtask

	// Compare each delivered report with the oldest one predicted
	always @(posedge clk) begin
		window_report_t want;
		if (arst_n && out_valid && out_ready) begin
			report_count++;
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected report", 0, 1);
			end else begin
				want = pending_reports.pop_front();
				if (found !== want.found)
					report_mismatch("found", 32'(want.found), 32'(found));
				if (shortest_length !== want.length)
					report_mismatch("shortest_length", 32'(want.length),
						32'(shortest_length));
				if (overflow !== want.overflow)
					report_mismatch("overflow", 32'(want.overflow), 32'(overflow));
			end
		end
	end

	// Sequence state back to empty; threshold untouched
	function automatic void clear_window();
		win_head     = '0;
		win_tail     = '0;
		win_len      = '0;
		win_sum      = '0;
		best_len     = '0;
		best_ok      = 1'b0;
		seq_samples  = '0;
		seq_overflow = 1'b0;
	endfunction

	// Push one sample, then shrink from the oldest end while the sum is above threshold
	function automatic void window_push(logic [SAMPLE_BITS-1:0] v);
		if (seq_samples >= LEN_W'(MAX_LEN)) begin
			seq_overflow = 1'b1;
			return;
		end
		win_mem[win_tail] = v;
		win_tail = (win_tail == PTR_W'(MAX_LEN - 1)) ? '0 : win_tail + 1'b1;
		win_len++;
		seq_samples++;
		win_sum += 21'(v);
		while (win_sum > {1'b0, thr_reg} && win_len != 0) begin
			if (!best_ok || win_len < best_len) begin
				best_len = win_len;
				best_ok  = 1'b1;
			end
			win_sum -= 21'(win_mem[win_head]);
			win_head = (win_head == PTR_W'(MAX_LEN - 1)) ? '0 : win_head + 1'b1;
			win_len--;
		end
	endfunction

	function automatic void window_request(logic cmd, logic [SAMPLE_BITS-1:0] v);
		window_report_t r;
		if (cmd == swot_pkg::CMD_PUSH) begin
			window_push(v);
		end else begin
			r.found    = best_ok;
			r.length   = best_ok ? best_len : '0;
			r.overflow = seq_overflow;
			pending_reports.push_back(r);
			clear_window();
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	// Every call must be followed at once by another send or by wait_idle.
	task automatic send_request(logic cmd, logic [SAMPLE_BITS-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		sample_value <= v;
		do @(posedge clk); while (!in_ready);
		window_request(cmd, v);
		request_count++;
		@(negedge clk);
	endtask

	// Drain everything, then let any trimming finish before touching the register
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= THR_W'($urandom());
		thr_reg = v;
		cfg_count++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return SAMPLE_BITS'($urandom_range(0, 15));
			1: return $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : '0;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 3))
			0: return THR_W'($urandom_range(0, 40));
			1: return THR_W'($urandom_range(500, 1500));
			2: return THR_W'($urandom_range(0, 4000));
			default: return THR_W'($urandom());
		endcase
	endfunction

	// Hand-picked sequences: reset threshold, empty sequence, both threshold extremes
	task automatic test_directed();
		send_request(swot_pkg::CMD_END, '0);
		send_request(swot_pkg::CMD_PUSH, 10'd21);
		send_request(swot_pkg::CMD_END, '0);
		send_request(swot_pkg::CMD_PUSH, 10'd0);
		send_request(swot_pkg::CMD_PUSH, 10'd0);
		send_request(swot_pkg::CMD_PUSH, 10'd20);
		send_request(swot_pkg::CMD_END, 10'h3FF);
		send_request(swot_pkg::CMD_PUSH, 10'd10);
		send_request(swot_pkg::CMD_PUSH, 10'd10);
		send_request(swot_pkg::CMD_PUSH, 10'd1);
		send_request(swot_pkg::CMD_PUSH, 10'd1023);
		send_request(swot_pkg::CMD_END, '0);
		wait_idle();
		write_threshold('0);
		send_request(swot_pkg::CMD_PUSH, 10'd0);
		send_request(swot_pkg::CMD_END, '0);
		send_request(swot_pkg::CMD_PUSH, 10'd0);
		send_request(swot_pkg::CMD_PUSH, 10'd1);
		send_request(swot_pkg::CMD_END, '0);
		wait_idle();
		write_threshold(THR_MAX);
		send_request(swot_pkg::CMD_PUSH, 10'd1023);
		send_request(swot_pkg::CMD_PUSH, 10'd1023);
		send_request(swot_pkg::CMD_PUSH, 10'd1023);
		send_request(swot_pkg::CMD_END, '0);
		wait_idle();
	endtask

	// Only the whole full window qualifies, so the longest length is reported;
	// the extra pushes after it are dropped and flagged, and the flag then clears
	task automatic test_full_and_overflow();
		int extra;
		extra = $urandom_range(1, 8);
		write_threshold(THR_W'(MAX_LEN * 1023 - 1));
		for (int i = 0; i < MAX_LEN + extra; i++)
			send_request(swot_pkg::CMD_PUSH, {SAMPLE_BITS{1'b1}});
		send_request(swot_pkg::CMD_END, '0);
		send_request(swot_pkg::CMD_END, '0);
		wait_idle();
	endtask

	// Random sequences under one traffic profile, two threshold settings
	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		write_threshold(pick_threshold());
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2) begin
				wait_idle();
				write_threshold(pick_threshold());
			end
			send_request(($urandom_range(0, 6) == 0) ? swot_pkg::CMD_END : swot_pkg::CMD_PUSH,
				pick_sample());
		end
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		write_threshold(THR_W'($urandom_range(20, 300)));
		hold_request = 400;
		for (int i = 0; i < 40; i++)
			send_request((i % 3 == 2) ? swot_pkg::CMD_END : swot_pkg::CMD_PUSH, pick_sample());
		send_request(swot_pkg::CMD_END, '0);
		wait_idle();
	endtask

	initial begin
		thr_reg = swot_pkg::THR_RESET;
		clear_window();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_full_and_overflow();
		test_random_traffic(0, 0, 70);
		test_random_traffic(51, 0, 70);
		test_random_traffic(0, 51, 70);
		test_random_traffic(11, 11, 70);
		test_backpressure();
		wait_idle();

		if (pending_reports.size() != 0)
			report_mismatch("reports never delivered", 0, pending_reports.size());
		$display("Sent %0d requests and checked %0d reports over %0d threshold settings,",
			request_count, report_count, cfg_count);
		$display("including full and overflowing windows, stalls and a long hold-off.");
		if (error_count == 0) begin
			$display("shortest_window_over_threshold_core: match");
		end else begin
			$display("shortest_window_over_threshold_core: mismatch");
		end
		$finish;
	end

endmodule
